// File: src/rgb_3x3_convolution_clamp_macros.svh
// Assertion shorthands, clocked on clk and held off during rst.
`ifndef RGB_3X3_CONVOLUTION_CLAMP_MACROS_SVH
`define RGB_3X3_CONVOLUTION_CLAMP_MACROS_SVH

// same-cycle implication
`define RGB3C_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RGB3C_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rgb3c_pkg.sv
`default_nettype none
package rgb3c_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int COEF_FRAC_DEF  = 12;
  localparam int HEIGHT_LIMIT   = 4096;

  localparam int PIX_W    = 24;
  localparam int CHAN_W   = 8;
  localparam int COEF_W   = 18;
  localparam int KROW_W   = 54;
  localparam int IMG_W_W  = 12;
  localparam int IMG_H_W  = 13;
  localparam int ROW_W    = 13;
  localparam int PROD_W   = 27;
  localparam int RSUM_W   = 29;
  localparam int ACC_W    = 31;
  localparam int TAPS     = 9;
  localparam int LANES    = 3;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;

  localparam logic [2:0] REG_KTOP   = 3'd0;
  localparam logic [2:0] REG_KMID   = 3'd1;
  localparam logic [2:0] REG_KBOT   = 3'd2;
  localparam logic [2:0] REG_WIDTH  = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;

  localparam logic [KROW_W-1:0]  KTOP_RST   = 54'd0;
  localparam logic [KROW_W-1:0]  KMID_RST   = 54'd1073741824;
  localparam logic [KROW_W-1:0]  KBOT_RST   = 54'd0;
  localparam logic [IMG_W_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [IMG_H_W-1:0] HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } mask_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              frame_end;
  } res_t;

  function automatic logic signed [COEF_W-1:0] coef_of(input logic [KROW_W-1:0] row,
                                                       input int col);
    coef_of = $signed(row[COEF_W*col +: COEF_W]);
  endfunction

endpackage
`default_nettype wire

// File: src/rgb3c_if.sv
`default_nettype none
interface rgb3c_pix_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, command, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, command, in_red, in_green, in_blue, output ready);
endinterface

interface rgb3c_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface
`default_nettype wire

// File: src/rgb3c_line.sv
`default_nettype none
module rgb3c_line import rgb3c_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         acc,
  input  wire logic                         v1,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] addr,
  input  wire logic [PIX_W-1:0]             pix,
  output logic      [PIX_W-1:0]             window_next [TAPS]
);

  localparam int XW = $clog2(MAX_WIDTH);

  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic [XW-1:0]    addr1;
  logic [PIX_W-1:0] pix1;
  logic [PIX_W-1:0] up_rd;
  logic [PIX_W-1:0] mid_rd;
  logic             fwd;
  logic [PIX_W-1:0] fwd_up;
  logic [PIX_W-1:0] fwd_mid;
  logic [PIX_W-1:0] up_cur;
  logic [PIX_W-1:0] mid_cur;
  logic [PIX_W-1:0] window [TAPS];
  logic             wr;

  assign wr      = v1 && en;
  assign up_cur  = fwd ? fwd_up : up_rd;
  assign mid_cur = fwd ? fwd_mid : mid_rd;

  always_ff @(posedge clk) begin
    if (acc) begin
      up_rd   <= upper_mem[addr];
      mid_rd  <= middle_mem[addr];
      addr1   <= addr;
      pix1    <= pix;
      fwd     <= wr && (addr == addr1);
      fwd_up  <= mid_cur;
      fwd_mid <= pix1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      upper_mem[addr1]  <= mid_cur;
      middle_mem[addr1] <= pix1;
    end
  end

  always_comb begin
    window_next = window;
    if (v1) begin
      for (int r = 0; r < 3; r++) begin
        window_next[3*r]   = window[3*r+1];
        window_next[3*r+1] = window[3*r+2];
      end
      window_next[2] = up_cur;
      window_next[5] = mid_cur;
      window_next[8] = pix1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) window[i] <= '0;
    end else if (en) begin
      window <= window_next;
    end
  end

endmodule
`default_nettype wire

// File: src/rgb3c_lane.sv
`default_nettype none
module rgb3c_lane import rgb3c_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [CHAN_W-1:0]        taps  [TAPS],
  input  wire logic signed [COEF_W-1:0] coefs [TAPS],
  input  wire mask_t                    mask,
  output logic [CHAN_W-1:0]             res
);

  localparam int SH_W = ACC_W - COEF_FRAC_BITS;

  logic signed [COEF_W-1:0] kz        [TAPS];
  logic signed [PROD_W-1:0] prod_next [TAPS];
  logic signed [PROD_W-1:0] prod      [TAPS];
  logic signed [RSUM_W-1:0] rsum_next [3];
  logic signed [RSUM_W-1:0] rsum      [3];
  logic signed [ACC_W-1:0]  total;
  logic [SH_W-1:0]          sh;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && mask.top) || (r == 2 && mask.bottom) ||
            (c == 0 && mask.left) || (c == 2 && mask.right)) begin
          kz[3*r+c]        = '0;
          prod_next[3*r+c] = '0;
        end else begin
          kz[3*r+c]        = coefs[3*r+c];
          prod_next[3*r+c] = $signed({1'b0, taps[3*r+c]}) * kz[3*r+c];
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rsum_next[r] = RSUM_W'(prod[3*r]) + RSUM_W'(prod[3*r+1]) + RSUM_W'(prod[3*r+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
      rsum <= rsum_next;
    end
  end

  assign total = ACC_W'(rsum[0]) + ACC_W'(rsum[1]) + ACC_W'(rsum[2]);
  assign sh    = total[ACC_W-1:COEF_FRAC_BITS];

  always_comb begin
    if (total[ACC_W-1]) begin
      res = '0;
    end else if (|sh[SH_W-2:CHAN_W]) begin
      res = CHAN_MAX;
    end else begin
      res = sh[CHAN_W-1:0];
    end
  end

endmodule
`default_nettype wire

// File: src/rgb3c_merge.sv
`default_nettype none
`include "rgb_3x3_convolution_clamp_macros.svh"
module rgb3c_merge import rgb3c_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire res_t    in_data,
  output logic         en,
  rgb3c_res_if.source  res
);

  res_t head;
  res_t skid;
  logic head_v;
  logic skid_v;

  assign en = !skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (res.ready) begin
        head_v <= 1'b1;
        skid_v <= 1'b0;
      end
    end else if (in_valid) begin
      if (!head_v || res.ready) begin
        head_v <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end else if (res.ready) begin
      head_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (res.ready) head <= skid;
    end else if (in_valid) begin
      if (!head_v || res.ready) begin
        head <= in_data;
      end else begin
        skid <= in_data;
      end
    end
  end

  assign res.valid     = head_v;
  assign res.out_red   = head.red;
  assign res.out_green = head.green;
  assign res.out_blue  = head.blue;
  assign res.frame_end = head.frame_end;

  `RGB3C_ASSERT_IMP(a_skid_behind_head, skid_v, head_v, "skid holds data with head empty")
  `RGB3C_ASSERT_NXT(a_result_lands, in_valid && !skid_v, head_v, "result lost at output")
  `RGB3C_ASSERT_NXT(a_skid_holds, skid_v && !res.ready, skid_v, "skid dropped while stalled")

endmodule
`default_nettype wire

// File: src/rgb_3x3_convolution_clamp.sv
// Streaming 3x3 convolution of RGB pixels in raster order: one pixel transfer per clock on
// the pixels channel, one result per clock on the results channel (both while results are
// taken), three parallel channel lanes sharing one 3x3 kernel of 18-bit signed
// coefficients, feeding a merge stage with a skid register. A result passes line, product,
// row-sum and merge registers; the output lags the input by one row and one pixel, so after
// the frame the host sends image_width+1 drain items (command 1). Rate is set by the two
// line stores, each read once and written once per clock at the pixel's column. Writing
// image_width or image_height restarts the frame; kernel writes apply to the next result.
// Out of range geometry is clamped (0 acts as 1, width above MAX_WIDTH as MAX_WIDTH, height
// above 4096 as 4096). Registers sit at byte offsets 8*i on a 64-bit APB port.
`default_nettype none
module rgb_3x3_convolution_clamp import rgb3c_pkg::*; #(
  parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  rgb3c_pix_if.sink                  pixels,
  rgb3c_res_if.source                results,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = XW + 1;

  logic [KROW_W-1:0]  k_top;
  logic [KROW_W-1:0]  k_mid;
  logic [KROW_W-1:0]  k_bot;
  logic [IMG_W_W-1:0] img_w;
  logic [IMG_H_W-1:0] img_h;

  logic [2:0] idx;
  logic       wr;
  logic       geo_wr;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_ADDR_W-1:3];
  assign wr     = psel && penable && pwrite;
  assign geo_wr = wr && (idx == REG_WIDTH || idx == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      k_top <= KTOP_RST;
      k_mid <= KMID_RST;
      k_bot <= KBOT_RST;
      img_w <= WIDTH_RST;
      img_h <= HEIGHT_RST;
    end else if (wr) begin
      case (idx)
        REG_KTOP:   k_top <= pwdata[KROW_W-1:0];
        REG_KMID:   k_mid <= pwdata[KROW_W-1:0];
        REG_KBOT:   k_bot <= pwdata[KROW_W-1:0];
        REG_WIDTH:  img_w <= pwdata[IMG_W_W-1:0];
        REG_HEIGHT: img_h <= pwdata[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KTOP:   prdata = CFG_DATA_W'(k_top);
      REG_KMID:   prdata = CFG_DATA_W'(k_mid);
      REG_KBOT:   prdata = CFG_DATA_W'(k_bot);
      REG_WIDTH:  prdata = CFG_DATA_W'(img_w);
      REG_HEIGHT: prdata = CFG_DATA_W'(img_h);
      default:    prdata = '0;
    endcase
  end

  logic [WW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;

  always_comb begin
    if (img_w == '0) begin
      w_eff = WW'(1);
    end else if (32'(img_w) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(img_w);
    end
    if (img_h == '0) begin
      h_eff = ROW_W'(1);
    end else if (32'(img_h) > 32'(HEIGHT_LIMIT)) begin
      h_eff = ROW_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = ROW_W'(img_h);
    end
  end

  logic [XW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic [XW-1:0]    col_next;
  logic [ROW_W-1:0] row_next;
  logic [WW-1:0]    ci;
  logic [WW-1:0]    ci_inc;
  logic [WW-1:0]    ox;
  logic [ROW_W-1:0] oy;
  logic             emit;
  mask_t            mask0;
  logic             fe0;
  logic             acc;
  logic             en;

  assign acc = pixels.valid && pixels.ready;
  assign pixels.ready = en;

  always_comb begin
    ci = ({1'b0, col} >= w_eff) ? w_eff - WW'(1) : {1'b0, col};
    if (ci != '0) begin
      emit = row >= ROW_W'(1);
      oy   = row - ROW_W'(1);
      ox   = ci - WW'(1);
    end else begin
      emit = row >= ROW_W'(2);
      oy   = row - ROW_W'(2);
      ox   = w_eff - WW'(1);
    end
    emit         = emit && (oy < h_eff);
    mask0.top    = oy == '0;
    mask0.bottom = oy == h_eff - ROW_W'(1);
    mask0.left   = ox == '0;
    mask0.right  = ox == w_eff - WW'(1);
    fe0          = mask0.bottom && mask0.right;

    ci_inc = ci + WW'(1);
    if (ci_inc >= w_eff) begin
      col_next = '0;
      row_next = row + ROW_W'(1);
    end else begin
      col_next = ci_inc[XW-1:0];
      row_next = row;
    end
    if (row_next > h_eff + ROW_W'(1)) row_next = h_eff + ROW_W'(1);
    if (emit && fe0) begin
      col_next = '0;
      row_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || geo_wr) begin
      col <= '0;
      row <= '0;
    end else if (acc) begin
      col <= col_next;
      row <= row_next;
    end
  end

  logic  v1;
  logic  vp;
  logic  vr;
  logic  emit1;
  mask_t mask1;
  logic  fe1;
  logic  fep;
  logic  fer;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      vp <= 1'b0;
      vr <= 1'b0;
    end else if (en) begin
      v1 <= pixels.valid;
      vp <= v1 && emit1;
      vr <= vp;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      emit1 <= emit;
      mask1 <= mask0;
      fe1   <= fe0;
    end
    if (en) begin
      fep <= fe1;
      fer <= fep;
    end
  end

  logic [PIX_W-1:0] pix0;
  logic [PIX_W-1:0] window_next [TAPS];

  assign pix0 = pixels.command ? '0 : {pixels.in_red, pixels.in_green, pixels.in_blue};

  rgb3c_line #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .acc         (acc),
    .v1          (v1),
    .addr        (ci[XW-1:0]),
    .pix         (pix0),
    .window_next (window_next)
  );

  logic signed [COEF_W-1:0] coefs     [TAPS];
  logic [CHAN_W-1:0]        lane_taps [LANES][TAPS];
  logic [CHAN_W-1:0]        lane_res  [LANES];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      coefs[c]   = coef_of(k_top, c);
      coefs[3+c] = coef_of(k_mid, c);
      coefs[6+c] = coef_of(k_bot, c);
    end
    for (int l = 0; l < LANES; l++) begin
      for (int i = 0; i < TAPS; i++) begin
        lane_taps[l][i] = window_next[i][PIX_W-1-CHAN_W*l -: CHAN_W];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    rgb3c_lane #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (en),
      .taps  (lane_taps[l]),
      .coefs (coefs),
      .mask  (mask1),
      .res   (lane_res[l])
    );
  end

  res_t merged;

  assign merged.red       = lane_res[0];
  assign merged.green     = lane_res[1];
  assign merged.blue      = lane_res[2];
  assign merged.frame_end = fer;

  rgb3c_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vr),
    .in_data  (merged),
    .en       (en),
    .res      (results)
  );

endmodule
`default_nettype wire

// File: verif/conv_result_checker.sv
`timescale 1ns / 1ps
module conv_result_checker import rgb3c_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  rgb3c_pix_if                  pix,
  rgb3c_res_if                  res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    mismatches,
  output int                    outstanding
);

  logic [KROW_W-1:0]  kernel_row [3];
  logic [IMG_W_W-1:0] width_reg;
  logic [IMG_H_W-1:0] height_reg;
  logic [PIX_W-1:0]   line_two_up [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]   line_one_up [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]   taps [3][3];
  int unsigned        next_col;
  int unsigned        next_row;
  res_t               expected_px [$];

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [CHAN_W-1:0] settle_channel(input longint acc);
    longint q;
    if (acc < 0) return '0;
    q = acc >>> COEF_FRAC_DEF;
    if (q > longint'(CHAN_MAX)) return CHAN_MAX;
    return q[CHAN_W-1:0];
  endfunction

  task automatic apply_write(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_KTOP: kernel_row[0] = value[KROW_W-1:0];
      REG_KMID: kernel_row[1] = value[KROW_W-1:0];
      REG_KBOT: kernel_row[2] = value[KROW_W-1:0];
      REG_WIDTH: begin
        width_reg = value[IMG_W_W-1:0];
        next_col = 0;
        next_row = 0;
      end
      REG_HEIGHT: begin
        height_reg = value[IMG_H_W-1:0];
        next_col = 0;
        next_row = 0;
      end
      default: ;
    endcase
  endtask

  task automatic slide_window(input logic drain, input logic [PIX_W-1:0] px);
    int unsigned w, h, ci, ri, ox, oy;
    int r, c, ch, x, y;
    logic emit;
    logic [PIX_W-1:0] incoming;
    longint acc [3];
    longint k;
    res_t item;

    if (width_reg == '0) w = 1;
    else if (width_reg > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    else w = width_reg;
    if (height_reg == '0) h = 1;
    else if (height_reg > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
    else h = height_reg;

    ci = next_col;
    ri = next_row;
    ox = 0;
    oy = 0;
    if (ci >= w) ci = w - 1;
    incoming = drain ? '0 : px;

    for (r = 0; r < 3; r++) begin
      taps[r][0] = taps[r][1];
      taps[r][1] = taps[r][2];
    end
    taps[0][2] = line_two_up[ci];
    taps[1][2] = line_one_up[ci];
    taps[2][2] = incoming;
    line_two_up[ci] = line_one_up[ci];
    line_one_up[ci] = incoming;

    emit = 1'b0;
    if (ci >= 1) begin
      if (ri >= 1) begin
        emit = 1'b1;
        ox = ci - 1;
        oy = ri - 1;
      end
    end else if (ri >= 2) begin
      emit = 1'b1;
      ox = w - 1;
      oy = ri - 2;
    end
    if (emit && oy >= h) emit = 1'b0;

    ci++;
    if (ci >= w) begin
      ci = 0;
      ri++;
    end
    if (ri > h + 1) ri = h + 1;
    next_col = ci;
    next_row = ri;

    if (emit) begin
      for (ch = 0; ch < 3; ch++) acc[ch] = 0;
      for (r = 0; r < 3; r++) begin
        y = int'(oy) + r - 1;
        if (y < 0 || y >= int'(h)) continue;
        for (c = 0; c < 3; c++) begin
          x = int'(ox) + c - 1;
          if (x < 0 || x >= int'(w)) continue;
          k = longint'($signed(kernel_row[r][COEF_W*c +: COEF_W]));
          for (ch = 0; ch < 3; ch++)
            acc[ch] += longint'(taps[r][c][CHAN_W*(2-ch) +: CHAN_W]) * k;
        end
      end
      item.red       = settle_channel(acc[0]);
      item.green     = settle_channel(acc[1]);
      item.blue      = settle_channel(acc[2]);
      item.frame_end = (oy == h - 1) && (ox == w - 1);
      expected_px.push_back(item);
      if (item.frame_end) begin
        next_col = 0;
        next_row = 0;
      end
    end
  endtask

  task automatic check_result();
    res_t want;
    if (expected_px.size() == 0) begin
      report($sformatf("result with nothing expected: %0d %0d %0d end %0b",
                       res.out_red, res.out_green, res.out_blue, res.frame_end));
      return;
    end
    want = expected_px.pop_front();
    if (res.out_red !== want.red)
      report($sformatf("red got %0d want %0d", res.out_red, want.red));
    if (res.out_green !== want.green)
      report($sformatf("green got %0d want %0d", res.out_green, want.green));
    if (res.out_blue !== want.blue)
      report($sformatf("blue got %0d want %0d", res.out_blue, want.blue));
    if (res.frame_end !== want.frame_end)
      report($sformatf("frame_end got %0b want %0b", res.frame_end, want.frame_end));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      kernel_row[0] = KTOP_RST;
      kernel_row[1] = KMID_RST;
      kernel_row[2] = KBOT_RST;
      width_reg = WIDTH_RST;
      height_reg = HEIGHT_RST;
      foreach (taps[r, c]) taps[r][c] = '0;
      foreach (line_one_up[i]) begin
        line_one_up[i] = '0;
        line_two_up[i] = '0;
      end
      next_col = 0;
      next_row = 0;
      expected_px.delete();
    end else begin
      if (psel && penable && pwrite && pready)
        apply_write(paddr[CFG_ADDR_W-1:3], pwdata);
      if (pix.valid && pix.ready)
        slide_window(pix.command, {pix.in_red, pix.in_green, pix.in_blue});
      if (res.valid && res.ready)
        check_result();
    end
    outstanding <= expected_px.size();
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench import rgb3c_pkg::*;;

  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int END_WAIT      = 100_000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatches;
  int                    outstanding;
  int unsigned           cycle_count = 0;
  logic                  idle_gaps;
  int                    random_sent;

  rgb3c_pix_if pix_ch ();
  rgb3c_res_if res_ch ();

  rgb_3x3_convolution_clamp uut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_ch),
    .results (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  conv_result_checker chk (
    .clk         (clk),
    .rst         (rst),
    .pix         (pix_ch),
    .res         (res_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int pick_gap(input int longest);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, longest);
  endfunction

  function automatic logic [CHAN_W-1:0] pick_channel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CHAN_MAX;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef(input int style);
    if (style == 0) return COEF_W'($urandom_range(0, 1200)) - COEF_W'(200);
    if (style == 2) return COEF_W'($urandom);
    case ($urandom_range(0, 8))
      0: return '0;
      1: return COEF_W'(4096);
      2: return -COEF_W'(4096);
      3: return COEF_W'(8192);
      4: return -COEF_W'(8192);
      5: return COEF_W'(455);
      6: return 18'h1FFFF;
      7: return 18'h20000;
      default: return COEF_W'(2048);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] kernel_word(input int style);
    logic [CFG_DATA_W-1:0] value;
    value = {10'($urandom), pick_coef(style), pick_coef(style), pick_coef(style)};
    if ($urandom_range(0, 1) == 0) value[CFG_DATA_W-1:KROW_W] = '0;
    return value;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] noisy(input logic [15:0] field);
    logic [CFG_DATA_W-1:0] value;
    value = CFG_DATA_W'(field);
    if ($urandom_range(0, 3) == 0) value[CFG_DATA_W-1:16] = {$urandom, 16'($urandom)};
    return value;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_kernels(input int style);
    write_reg(REG_KTOP, kernel_word(style));
    write_reg(REG_KMID, kernel_word(style));
    write_reg(REG_KBOT, kernel_word(style));
  endtask

  task automatic write_geometry(input int w, input int h);
    write_reg(REG_WIDTH, noisy(16'(w)));
    write_reg(REG_HEIGHT, noisy(16'(h)));
  endtask

  // hold until every expected transfer is back, then let the pipe drain
  task automatic settle();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send(input logic drain, input logic [CHAN_W-1:0] r, g, b, input logic hold);
    int gap;
    gap = idle_gaps ? pick_gap(60) : 0;
    if (hold) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
      while (outstanding != 0) @(posedge clk);
    end else if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid    <= 1'b1;
    pix_ch.command  <= drain;
    pix_ch.in_red   <= r;
    pix_ch.in_green <= g;
    pix_ch.in_blue  <= b;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
  endtask

  task automatic send_random(input logic drain);
    send(drain, pick_channel(), pick_channel(), pick_channel(), $urandom_range(0, 299) == 0);
    random_sent++;
  endtask

  task automatic send_frame(input int w, input int h);
    idle_gaps = $urandom_range(0, 4) != 0;
    repeat (w * h) send_random($urandom_range(0, 99) < 3);
    repeat (w + 1) send_random($urandom_range(0, 99) >= 3);
    if ($urandom_range(0, 19) == 0) repeat ($urandom_range(1, 3)) send_random(1'b1);
  endtask

  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if ($urandom_range(0, 9) == 0) repeat (150) @(posedge clk);
      stall = pick_gap(40);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    int w, h, ew, eh;
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    pix_ch.valid    <= 1'b0;
    pix_ch.command  <= 1'b0;
    pix_ch.in_red   <= '0;
    pix_ch.in_green <= '0;
    pix_ch.in_blue  <= '0;
    idle_gaps = 1'b1;
    random_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_geometry(3, 2);
    send(1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
    send(1'b0, 8'd255, 8'd255, 8'd255, 1'b0);
    send(1'b0, 8'd1, 8'd128, 8'd254, 1'b0);
    send(1'b1, 8'd9, 8'd9, 8'd9, 1'b0);
    send(1'b0, 8'd255, 8'd0, 8'd127, 1'b0);
    send(1'b0, 8'h55, 8'hAA, 8'h0F, 1'b0);
    send(1'b1, 8'd7, 8'd7, 8'd7, 1'b0);
    send(1'b0, 8'd255, 8'd255, 8'd255, 1'b0);
    send(1'b1, 8'd0, 8'd0, 8'd0, 1'b0);
    send(1'b1, 8'd0, 8'd0, 8'd0, 1'b0);
    settle();

    write_reg(REG_KTOP, {10'h3FF, {3{18'h1FFFF}}});
    write_reg(REG_KMID, CFG_DATA_W'({3{18'h1FFFF}}));
    write_reg(REG_KBOT, CFG_DATA_W'({3{18'h1FFFF}}));
    write_geometry(2, 1);
    send(1'b0, 8'd1, 8'd0, 8'd0, 1'b0);
    send(1'b0, 8'd0, 8'd0, 8'd1, 1'b0);
    repeat (4) send(1'b1, 8'd0, 8'd0, 8'd0, 1'b0);
    settle();

    write_reg(REG_KTOP, CFG_DATA_W'({3{18'h20000}}));
    write_reg(REG_KMID, {10'h3FF, {3{18'h20000}}});
    write_reg(REG_KBOT, CFG_DATA_W'({3{18'h20000}}));
    write_geometry(1, 1);
    send(1'b0, 8'd255, 8'd255, 8'd255, 1'b0);
    repeat (2) send(1'b1, 8'd0, 8'd0, 8'd0, 1'b0);

    ew = 1;
    eh = 1;
    while (random_sent < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 9) < 7) begin
        w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
        h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
        write_geometry(w, h);
        ew = (w == 0) ? 1 : w;
        eh = (h == 0) ? 1 : h;
      end
      write_kernels($urandom_range(0, 2));
      repeat ($urandom_range(1, 4)) send_frame(ew, eh);
    end

    settle();
    write_kernels(0);
    write_geometry(4095, 1);
    repeat (40) send_random(1'b0);
    settle();
    write_geometry(MAX_WIDTH_DEF, HEIGHT_LIMIT);
    repeat (10) send_random(1'b0);
    settle();
    write_kernels(1);
    write_geometry(0, 8191);
    repeat (40) send_random(1'b0);

    pix_ch.valid <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < END_WAIT && outstanding != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/rgb3c_pkg.sv
src/rgb3c_if.sv
src/rgb3c_line.sv
src/rgb3c_lane.sv
src/rgb3c_merge.sv
src/rgb_3x3_convolution_clamp.sv
verif/conv_result_checker.sv
verif/testbench.sv
